/* rtl/core/escr_pkg.sv */
// package with shared types and constants of the extent sector remap coalescer
package escr_pkg;

  localparam int unsigned MaxExtents = 64;
  localparam int unsigned MaxSectors = 64;
  localparam int unsigned IdxW       = $clog2(MaxExtents);
  localparam int unsigned CntW       = $clog2(MaxExtents + 1);
  localparam int unsigned SecW       = 7;
  localparam int unsigned ImgW       = 34;
  localparam int unsigned DiskW      = 64;
  localparam int unsigned LbaW       = 48;
  localparam int unsigned QDepth     = 2;

  typedef enum logic [1:0] {
    ActClear     = 2'd0,
    ActLoad      = 2'd1,
    ActTranslate = 2'd2,
    ActNone      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StRun     = 2'd0,
    StStored  = 2'd1,
    StFull    = 2'd2,
    StCleared = 2'd3
  } status_e;

  typedef struct packed {
    action_e            action;
    logic [ImgW-1:0]    img_first;
    logic [ImgW-1:0]    img_last;
    logic [DiskW-1:0]   disk_first;
    logic [LbaW-1:0]    lba;
    logic [SecW-1:0]    count;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [DiskW-1:0] disk;
    logic [SecW-1:0]  len;
    logic             last;
  } res_t;

endpackage

/* rtl/core/escr_front.sv */
// front end: classifies input beats into normalized commands and queues them
module escr_front import escr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [31:0] chunk_img_start_i,
  input  logic [31:0] chunk_img_end_i,
  input  logic [63:0] chunk_disk_start_i,
  input  logic [47:0] request_lba_i,
  input  logic [6:0]  sector_count_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_take_i
);

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            q_mem [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   fill_q, fill_d;
  cmd_t            cmd_in;
  logic            wr_en, rd_en;

  always_comb begin
    cmd_in.action     = action_e'(action_i);
    cmd_in.img_first  = {chunk_img_start_i, 2'b00};
    cmd_in.img_last   = {chunk_img_end_i, 2'b11};
    cmd_in.disk_first = chunk_disk_start_i;
    cmd_in.lba        = request_lba_i;
    if (sector_count_i == '0) begin
      cmd_in.count = SecW'(1);
    end else if (sector_count_i > SecW'(MaxSectors)) begin
      cmd_in.count = SecW'(MaxSectors);
    end else begin
      cmd_in.count = sector_count_i;
    end
  end

  assign full        = (fill_q == (PtrW+1)'(QDepth));
  assign wr_en       = push && !full && (action_e'(action_i) != ActNone);
  assign cmd_valid_o = (fill_q != '0);
  assign rd_en       = cmd_valid_o && cmd_take_i;
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    wr_d   = wr_en ? wr_q + PtrW'(1) : wr_q;
    rd_d   = rd_en ? rd_q + PtrW'(1) : rd_q;
    fill_d = fill_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

/* rtl/core/escr_back.sv */
// back end: extent table, sector search sequencer, run merging and result register
module escr_back import escr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cmd_valid_i,
  input  cmd_t   cmd_i,
  output logic   cmd_take_o,
  output logic   res_valid_o,
  output res_t   res_o,
  input  logic   res_take_i
);

  typedef enum logic [2:0] {
    SIdle, SRead, SCheck, SNext, SEmit
  } bstate_e;

  logic [ImgW-1:0]  img_first_mem [MaxExtents];
  logic [ImgW-1:0]  img_last_mem  [MaxExtents];
  logic [DiskW-1:0] disk_mem      [MaxExtents];

  bstate_e          state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [SecW-1:0]  sec_q, sec_d;
  logic [LbaW-1:0]  lba_q, lba_d;
  logic [SecW-1:0]  n_q, n_d;
  logic [DiskW-1:0] run_q, run_d;
  logic [SecW-1:0]  len_q, len_d;
  logic             have_q, have_d;
  logic [DiskW-1:0] map_q, map_d;
  logic             pend_q, pend_d;
  logic             rv_q, rv_d;
  res_t             res_q, res_d;
  logic [ImgW-1:0]  rf_q, rl_q;
  logic [DiskW-1:0] rd_q;
  logic             hit;
  logic             tbl_wr;
  logic             out_free;
  logic             more;
  logic             brk;

  assign res_valid_o = rv_q;
  assign res_o       = res_q;
  assign out_free    = !rv_q || res_take_i;
  assign more        = (sec_q + SecW'(1)) < n_q;
  assign brk         = have_q && (map_q != run_q + DiskW'(len_q));

  // lba compare in 49 bits against the 34-bit bounds
  logic [LbaW:0] cur_lba;
  assign cur_lba = {1'b0, lba_q} + (LbaW+1)'(sec_q);
  assign hit = (cur_lba >= (LbaW+1)'(rf_q)) && (cur_lba <= (LbaW+1)'(rl_q));

  assign tbl_wr = (state_q == SIdle) && cmd_valid_i && out_free &&
                  (cmd_i.action == ActLoad) && (count_q < CntW'(MaxExtents));

  always_ff @(posedge clk_i) begin
    if (tbl_wr) begin
      img_first_mem[count_q[IdxW-1:0]] <= cmd_i.img_first;
      img_last_mem[count_q[IdxW-1:0]]  <= cmd_i.img_last;
      disk_mem[count_q[IdxW-1:0]]      <= cmd_i.disk_first;
    end
    rf_q <= img_first_mem[idx_q[IdxW-1:0]];
    rl_q <= img_last_mem[idx_q[IdxW-1:0]];
    rd_q <= disk_mem[idx_q[IdxW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (cmd_valid_i && out_free && cmd_i.action == ActTranslate) begin
          state_d = (count_q == '0) ? SNext : SRead;
        end
      end
      SRead:  state_d = SCheck;
      SCheck: begin
        if (hit || idx_q + CntW'(1) >= count_q) begin
          state_d = SNext;
        end else begin
          state_d = SRead;
        end
      end
      SNext: begin
        if (brk || !more) begin
          state_d = SEmit;
        end else begin
          state_d = (count_q == '0) ? SNext : SRead;
        end
      end
      SEmit: begin
        if (out_free) begin
          if (!pend_q) begin
            state_d = SIdle;
          end else if (more) begin
            state_d = (count_q == '0) ? SNext : SRead;
          end else begin
            state_d = SEmit;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    sec_d      = sec_q;
    lba_d      = lba_q;
    n_d        = n_q;
    run_d      = run_q;
    len_d      = len_q;
    have_d     = have_q;
    map_d      = map_q;
    pend_d     = pend_q;
    rv_d       = rv_q && !res_take_i;
    res_d      = res_q;
    cmd_take_o = 1'b0;
    case (state_q)
      SIdle: begin
        if (cmd_valid_i && out_free) begin
          cmd_take_o = 1'b1;
          res_d.disk = '0;
          res_d.len  = '0;
          res_d.last = 1'b1;
          case (cmd_i.action)
            ActClear: begin
              count_d      = '0;
              rv_d         = 1'b1;
              res_d.status = StCleared;
            end
            ActLoad: begin
              rv_d = 1'b1;
              if (count_q < CntW'(MaxExtents)) begin
                count_d      = count_q + CntW'(1);
                res_d.status = StStored;
              end else begin
                res_d.status = StFull;
              end
            end
            ActTranslate: begin
              lba_d  = cmd_i.lba;
              n_d    = cmd_i.count;
              sec_d  = '0;
              idx_d  = '0;
              have_d = 1'b0;
              map_d  = '0;
              pend_d = 1'b0;
            end
            default: cmd_take_o = 1'b1;
          endcase
        end
      end
      SRead: ;
      SCheck: begin
        if (hit) begin
          map_d = DiskW'(cur_lba - (LbaW+1)'(rf_q)) + rd_q;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      SNext: begin
        // merge the mapped sector into the open run, or flag a pending break when it does not continue the run
        if (brk) begin
          pend_d = 1'b1;
        end else begin
          if (have_q) begin
            len_d = len_q + SecW'(1);
          end else begin
            run_d  = map_q;
            len_d  = SecW'(1);
            have_d = 1'b1;
          end
          if (more) begin
            sec_d = sec_q + SecW'(1);
            idx_d = '0;
            map_d = '0;
          end
        end
      end
      SEmit: begin
        if (out_free) begin
          rv_d         = 1'b1;
          res_d.status = StRun;
          res_d.disk   = run_q;
          res_d.len    = len_q;
          res_d.last   = !pend_q;
          if (pend_q) begin
            pend_d = 1'b0;
            run_d  = map_q;
            len_d  = SecW'(1);
            have_d = 1'b1;
            if (more) begin
              sec_d = sec_q + SecW'(1);
              idx_d = '0;
              map_d = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      idx_q   <= '0;
      sec_q   <= '0;
      n_q     <= '0;
      have_q  <= 1'b0;
      pend_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      sec_q   <= sec_d;
      n_q     <= n_d;
      have_q  <= have_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lba_q <= lba_d;
    run_q <= run_d;
    len_q <= len_d;
    map_q <= map_d;
    res_q <= res_d;
  end

endmodule

/* rtl/core/extent_sector_remap_coalescer_core.sv */
// top level of the extent sector remap coalescer
//  channel  | handshake   | beat
//  input    | push, full  | action, chunk fields, request_lba, sector_count
//  result   | empty, pop  | status, run_disk_sector, run_length, last
// clear and load results pass through the front queue and then the result register;
// a translate starts from the idle state, then for each sector reads and checks
// table entries up to the first hit, merges the mapped sector into the open run,
// and emits each finished run through the result register.
// the front queue holds two beats, so input is taken while the back end works.
// reset is asynchronous and active low and empties the table and queues.
module extent_sector_remap_coalescer_core import escr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [31:0] chunk_img_start_i,
  input  logic [31:0] chunk_img_end_i,
  input  logic [63:0] chunk_disk_start_i,
  input  logic [47:0] request_lba_i,
  input  logic [6:0]  sector_count_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [63:0] run_disk_sector_o,
  output logic [6:0]  run_length_o,
  output logic        last_o
);

  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;
  res_t res;

  escr_front u_front (
    .clk_i, .rst_ni, .push, .full, .action_i, .chunk_img_start_i,
    .chunk_img_end_i, .chunk_disk_start_i, .request_lba_i, .sector_count_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  escr_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(pop && res_valid)
  );

  assign empty             = !res_valid;
  assign status_o          = res.status;
  assign run_disk_sector_o = res.disk;
  assign run_length_o      = res.len;
  assign last_o            = res.last;

endmodule

/* dv/extent_sector_remap_coalescer_core_test.sv */
// testbench of the extent sector remap coalescer: table loads, clears and run translation
module extent_sector_remap_coalescer_core_test;
  import escr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action_i = '0;
  logic [31:0] chunk_img_start_i = '0;
  logic [31:0] chunk_img_end_i = '0;
  logic [63:0] chunk_disk_start_i = '0;
  logic [47:0] request_lba_i = '0;
  logic [6:0]  sector_count_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status_o;
  logic [63:0] run_disk_sector_o;
  logic [6:0]  run_length_o;
  logic        last_o;

  extent_sector_remap_coalescer_core dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  logic [ImgW-1:0]  tbl_first [MaxExtents];
  logic [ImgW-1:0]  tbl_last [MaxExtents];
  logic [DiskW-1:0] tbl_disk [MaxExtents];
  int unsigned      tbl_count = 0;
  res_t             runs_due [$];
  int unsigned      send_idle = 0;
  int unsigned      pop_stall = 0;
  int unsigned      mismatches = 0;
  int unsigned      beats_seen = 0;
  int unsigned      sectors_sent = 0;
  longint unsigned  cycle_count = 0;
  logic [DiskW-1:0] disk_base;

  task automatic report(input string what);
    $display("error at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic logic [DiskW-1:0] lookup_sector(input logic [LbaW:0] lba);
    for (int i = 0; i < tbl_count; i++) begin
      if (lba >= (LbaW+1)'(tbl_first[i]) && lba <= (LbaW+1)'(tbl_last[i]))
        return DiskW'(lba - (LbaW+1)'(tbl_first[i])) + tbl_disk[i];
    end
    return '0;
  endfunction

  function automatic res_t make_res(input status_e st, input logic [DiskW-1:0] d,
                                    input logic [SecW-1:0] n, input logic l);
    res_t r;
    r.status = st;
    r.disk = d;
    r.len = n;
    r.last = l;
    return r;
  endfunction

  task automatic predict_remap(input action_e act, input logic [31:0] s, input logic [31:0] e,
                               input logic [63:0] d, input logic [47:0] lba,
                               input logic [6:0] cnt);
    int unsigned      n;
    logic [DiskW-1:0] start, cur;
    logic [SecW-1:0]  len;
    case (act)
      ActClear: begin
        tbl_count = 0;
        runs_due.push_back(make_res(StCleared, '0, '0, 1'b1));
      end
      ActLoad: begin
        if (tbl_count >= MaxExtents) begin
          runs_due.push_back(make_res(StFull, '0, '0, 1'b1));
        end else begin
          tbl_first[tbl_count] = ImgW'({s, 2'b00});
          tbl_last[tbl_count] = ImgW'({e, 2'b11});
          tbl_disk[tbl_count] = d;
          tbl_count++;
          runs_due.push_back(make_res(StStored, '0, '0, 1'b1));
        end
      end
      ActTranslate: begin
        n = (cnt == 0) ? 1 : (cnt > MaxSectors ? MaxSectors : cnt);
        sectors_sent += n;
        start = lookup_sector({1'b0, lba});
        len = 1;
        for (int i = 1; i < n; i++) begin
          cur = lookup_sector({1'b0, lba} + (LbaW+1)'(i));
          if (cur == start + len) begin
            len++;
          end else begin
            runs_due.push_back(make_res(StRun, start, len, 1'b0));
            start = cur;
            len = 1;
          end
        end
        runs_due.push_back(make_res(StRun, start, len, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input action_e act, input logic [31:0] s, input logic [31:0] e,
                           input logic [63:0] d, input logic [47:0] lba,
                           input logic [6:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    action_i <= act;
    chunk_img_start_i <= s;
    chunk_img_end_i <= e;
    chunk_disk_start_i <= d;
    request_lba_i <= lba;
    sector_count_i <= cnt;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_remap(act, s, e, d, lba, cnt);
  endtask

  task automatic load_extent(input logic [31:0] s, input logic [31:0] e, input logic [63:0] d);
    send_beat(ActLoad, s, e, d, 48'($urandom), 7'($urandom));
  endtask

  task automatic translate(input logic [47:0] lba, input logic [6:0] cnt);
    send_beat(ActTranslate, $urandom, $urandom, {$urandom, $urandom}, lba, cnt);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && pop && !empty) begin
      res_t want;
      beats_seen++;
      if (runs_due.size() == 0) begin
        report($sformatf("unexpected beat status %0d", status_o));
      end else begin
        want = runs_due.pop_front();
        if (status_o !== want.status)
          report($sformatf("status %0d, want %0d", status_o, want.status));
        if (run_disk_sector_o !== want.disk)
          report($sformatf("disk %h, want %h", run_disk_sector_o, want.disk));
        if (run_length_o !== want.len)
          report($sformatf("length %0d, want %0d", run_length_o, want.len));
        if (last_o !== want.last)
          report($sformatf("last %0d, want %0d", last_o, want.last));
      end
    end
    pop <= ($urandom_range(99) >= pop_stall);
  end

  task automatic test_directed();
    send_beat(ActNone, '1, '1, '1, '1, '1);
    translate(48'd0, 7'd0);
    send_beat(ActClear, '0, '0, '0, '0, '0);
    load_extent(32'd2, 32'd5, 64'd100);
    load_extent(32'd4, 32'd8, 64'd1000);
    load_extent(32'd20, 32'd10, 64'd5);
    load_extent(32'hffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_fffe);
    load_extent(32'd30, 32'd30, 64'd1);
    translate(48'd0, 7'd64);
    translate(48'd118, 7'd4);
    translate(48'd6, 7'd127);
    translate(48'd5, 7'd70);
    translate(48'h3_ffff_fffc, 7'd8);
    translate(48'hffff_ffff_ffff, 7'd2);
    translate(48'd119, 7'd1);
    drain();
    send_beat(ActClear, '0, '0, '0, '0, '0);
    for (int i = 0; i < MaxExtents + 2; i++)
      load_extent(32'(i * 4), 32'(i * 4 + 1), {$urandom, $urandom});
    translate(48'd0, 7'd64);
    drain();
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned pick;
    logic [31:0] s;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_beat(ActClear, $urandom, $urandom, {$urandom, $urandom}, 48'($urandom),
                  7'($urandom));
      end else if (pick < 6) begin
        send_beat(ActNone, $urandom, $urandom, {$urandom, $urandom},
                  48'({$urandom, $urandom}), 7'($urandom));
      end else if (pick < 35) begin
        s = (pick < 30) ? $urandom_range(40) : $urandom;
        load_extent(s, (pick < 32) ? $urandom : s + $urandom_range(6) - 1,
                    (pick < 20) ? disk_base + $urandom_range(200) : {$urandom, $urandom});
      end else begin
        translate((pick < 90) ? 48'($urandom_range(200)) : 48'({$urandom, $urandom}),
                  (pick < 93) ? 7'($urandom) : 7'($urandom_range(1, 12)));
      end
    end
    drain();
  endtask

  initial begin
    disk_base = {$urandom, $urandom};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle = 58;
    test_random(70);
    send_idle = 0;
    pop_stall = 58;
    test_random(70);
    send_idle = 9;
    pop_stall = 9;
    test_random(70);
    send_idle = 0;
    pop_stall = 0;
    test_random(60);
    $display("covered %0d sectors translated and %0d result beats checked",
             sectors_sent, beats_seen);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    while (cycle_count < 64'd20_000_000) @(posedge clk_i);
    $display("timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule

/* extent_sector_remap_coalescer_core.f */
rtl/core/escr_pkg.sv
rtl/core/escr_front.sv
rtl/core/escr_back.sv
rtl/core/extent_sector_remap_coalescer_core.sv
dv/extent_sector_remap_coalescer_core_test.sv
